/* hw/rtl/npm_pkg.sv */
// Shared types and constants for the nearest point match-or-insert block.
package npm_pkg;

  localparam int COORD_IN_W = 16;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int IDX_OUT_W  = 8;
  localparam int DIST_W     = 17;
  localparam int DSQ_W      = 34;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    RES_MATCHED  = 3'd0,
    RES_INSERTED = 3'd1,
    RES_EMPTY    = 3'd2,
    RES_FULL     = 3'd3,
    RES_CLEARED  = 3'd4
  } res_status_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic decide;
    logic sqrt_start;
    logic out_load;
  } npm_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic table_empty;
    logic scan_last;
    logic pipe_empty;
    logic need_sqrt;
    logic sqrt_busy;
  } npm_sts_t;

endpackage

/* hw/rtl/npm_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module npm_isqrt #(
  parameter int W = 34
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   value,
  output logic           busy,
  output logic [W/2-1:0] root
);

  localparam int HW  = W / 2;
  localparam int RW  = HW + 2;
  localparam int CTW = $clog2(HW + 1);

  logic [W-1:0]   val;
  logic [RW-1:0]  rem;
  logic [CTW-1:0] cnt;
  logic [RW-1:0]  rem_sh;
  logic [RW-1:0]  trial;
  logic           ge;

  assign rem_sh = {rem[RW-3:0], val[W-1:W-2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CTW'(HW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[HW-2:0], ge};
    end
  end

endmodule

/* hw/rtl/npm_dp.sv */
// Datapath: point memory, distance pipeline, best tracking, decision and result registers.
module npm_dp #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  npm_pkg::npm_cmd_t                   cmd,
  output npm_pkg::npm_sts_t                   sts,
  input  logic [npm_pkg::REQ_W-1:0]           in_req,
  input  logic [npm_pkg::COORD_IN_W-1:0]      in_x,
  input  logic [npm_pkg::COORD_IN_W-1:0]      in_y,
  input  logic [npm_pkg::COORD_IN_W-1:0]      in_z,
  input  logic                                cfg_wr_en,
  input  logic [npm_pkg::DSQ_W-1:0]           cfg_wr_data,
  output logic [npm_pkg::STATUS_W-1:0]        out_status,
  output logic [npm_pkg::IDX_OUT_W-1:0]       out_index,
  output logic [npm_pkg::DIST_W-1:0]          out_dist,
  output logic [npm_pkg::DSQ_W-1:0]           out_dsq
);

  localparam int CW   = COORD_BITS;
  localparam int PW   = 2 * CW;
  localparam int SQW  = 2 * CW + 2;
  localparam int RTW  = SQW / 2;
  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (SQW > npm_pkg::DSQ_W) ? SQW : npm_pkg::DSQ_W;

  logic [npm_pkg::DSQ_W-1:0] match_dist_sq;
  logic [npm_pkg::REQ_W-1:0] req;
  logic signed [CW-1:0]      qx;
  logic signed [CW-1:0]      qy;
  logic signed [CW-1:0]      qz;
  logic [CNTW-1:0]           count;
  logic [IW-1:0]             rd_addr;

  logic [3*CW-1:0]           mem [TABLE_DEPTH];
  logic [3*CW-1:0]           rd_data;

  logic                      v0, v1, v2;
  logic [IW-1:0]             idx0, idx1, idx2;
  logic [PW-1:0]             sqx, sqy, sqz;
  logic [SQW-1:0]            sum;
  logic [CW-1:0]             dx, dy, dz;

  logic [SQW-1:0]            best_sq;
  logic [IW-1:0]             best_idx;
  logic                      best_valid;

  npm_pkg::res_status_t      res_status;
  logic [IW-1:0]             res_idx;
  logic [SQW-1:0]            res_dsq;
  logic                      res_use_root;

  logic                      full;
  logic                      empty;
  logic                      miss;
  logic                      do_insert;
  logic                      need_sqrt;
  npm_pkg::res_status_t      dec_status;
  logic [IW-1:0]             dec_idx;
  logic [SQW-1:0]            dec_dsq;

  logic                      sqrt_busy;
  logic [RTW-1:0]            root;

  function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    begin
      d = {a[CW-1], a} - {b[CW-1], b};
      if (d[CW]) begin
        d = -d;
      end
      return d[CW-1:0];
    end
  endfunction

  assign dx = abs_diff(rd_data[CW-1:0], qx);
  assign dy = abs_diff(rd_data[2*CW-1:CW], qy);
  assign dz = abs_diff(rd_data[3*CW-1:2*CW], qz);

  assign full      = count == CNTW'(TABLE_DEPTH);
  assign empty     = count == '0;
  assign miss      = (req == npm_pkg::REQ_INSERT) &&
                     (empty || (CMPW'(best_sq) > CMPW'(match_dist_sq)));
  assign do_insert = miss && !full;
  assign need_sqrt = !empty && !do_insert;

  always_comb begin
    if (do_insert) begin
      dec_status = npm_pkg::RES_INSERTED;
    end else if (empty) begin
      dec_status = npm_pkg::RES_EMPTY;
    end else if (miss) begin
      dec_status = npm_pkg::RES_FULL;
    end else begin
      dec_status = npm_pkg::RES_MATCHED;
    end
    dec_idx = do_insert ? IW'(count) : (empty ? '0 : best_idx);
    dec_dsq = empty ? '0 : best_sq;
  end

  assign sts.in_clear    = in_req == npm_pkg::REQ_CLEAR;
  assign sts.table_empty = empty;
  assign sts.scan_last   = (CNTW'(rd_addr) + 1'b1) == count;
  assign sts.pipe_empty  = !(v0 || v1 || v2);
  assign sts.need_sqrt   = need_sqrt;
  assign sts.sqrt_busy   = sqrt_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_dist_sq <= '0;
      count         <= '0;
      v0            <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      best_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        match_dist_sq <= cfg_wr_data;
      end
      v0 <= cmd.issue;
      v1 <= v0;
      v2 <= v1;
      if (cmd.load) begin
        best_valid <= 1'b0;
        if (in_req == npm_pkg::REQ_CLEAR) begin
          count <= '0;
        end
      end else if (v2) begin
        best_valid <= 1'b1;
      end
      if (cmd.decide && do_insert) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && do_insert) begin
      mem[IW'(count)] <= {qz, qy, qx};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req          <= in_req;
      qx           <= CW'($signed(in_x));
      qy           <= CW'($signed(in_y));
      qz           <= CW'($signed(in_z));
      rd_addr      <= '0;
      res_status   <= npm_pkg::RES_CLEARED;
      res_idx      <= '0;
      res_dsq      <= '0;
      res_use_root <= 1'b0;
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + 1'b1;
    end
    idx0 <= rd_addr;
    idx1 <= idx0;
    idx2 <= idx1;
    sqx  <= PW'(dx) * PW'(dx);
    sqy  <= PW'(dy) * PW'(dy);
    sqz  <= PW'(dz) * PW'(dz);
    sum  <= SQW'(sqx) + SQW'(sqy) + SQW'(sqz);
    if (v2 && (!best_valid || (sum < best_sq))) begin
      best_sq  <= sum;
      best_idx <= idx2;
    end
    if (cmd.decide) begin
      res_status   <= dec_status;
      res_idx      <= dec_idx;
      res_dsq      <= dec_dsq;
      res_use_root <= need_sqrt;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_index  <= npm_pkg::IDX_OUT_W'(res_idx);
      out_dsq    <= npm_pkg::DSQ_W'(res_dsq);
      out_dist   <= res_use_root ? npm_pkg::DIST_W'(root) : '0;
    end
  end

  npm_isqrt #(
    .W(SQW)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .value (best_sq),
    .busy  (sqrt_busy),
    .root  (root)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(TABLE_DEPTH))
    else $error("Point count exceeds the table depth.");

endmodule

/* hw/rtl/npm_ctrl.sv */
// Controller state machine sequencing accept, scan, decision, square root and result transfer.
module npm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  npm_pkg::npm_sts_t sts,
  output npm_pkg::npm_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_DECIDE = 6'b001000,
    S_SQRT   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_clear) begin
            state_next = S_DONE;
          end else if (sts.table_empty) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.need_sqrt) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SQRT: begin
        if (!sts.sqrt_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_accept_drops_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Input ready stayed high after an accepted transfer.");

  a_decide_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> sts.pipe_empty)
    else $error("Decision taken while distance pipeline still holds entries.");

  a_idle_sqrt_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.sqrt_busy)
    else $error("Square root unit busy while the controller is idle.");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("Output valid rose without a completed request.");

endmodule

/* hw/rtl/nearest_point_match_or_insert.sv */
// Top level of the nearest point match-or-insert block.
// One request is processed at a time. A clear goes straight from accept to the done state and
// reaches the output register once the output is free. Other requests scan one stored point per
// cycle, drain the distance pipeline, decide, run the square root when the result needs it and
// then wait in the done state for the output; an empty table skips the scan and the drain.
// Synchronous reset empties the table and zeroes the threshold; no clearing pass is needed.
module nearest_point_match_or_insert #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // query_x, query_y, query_z
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // point_index, nearest_dist, nearest_dist_sq, zero pad
  output logic [2:0]  m_axis_tuser,   // status
  input  logic        cfg_wr_en,
  input  logic [33:0] cfg_wr_data
);

  npm_pkg::npm_cmd_t                    cmd;
  npm_pkg::npm_sts_t                    sts;
  logic [npm_pkg::STATUS_W-1:0]         out_status;
  logic [npm_pkg::IDX_OUT_W-1:0]        out_index;
  logic [npm_pkg::DIST_W-1:0]           out_dist;
  logic [npm_pkg::DSQ_W-1:0]            out_dsq;

  npm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  npm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_req      (s_axis_tuser),
    .in_x        (s_axis_tdata[15:0]),
    .in_y        (s_axis_tdata[31:16]),
    .in_z        (s_axis_tdata[47:32]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_status  (out_status),
    .out_index   (out_index),
    .out_dist    (out_dist),
    .out_dsq     (out_dsq)
  );

  assign m_axis_tdata = {5'b00000, out_dsq, out_dist, out_index};
  assign m_axis_tuser = out_status;

endmodule

/* bench/nearest_point_match_or_insert_test.sv */
// Self-checking testbench for the nearest point match-or-insert block.
module nearest_point_match_or_insert_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int PHASE_ITEMS = 260;
  localparam longint unsigned DSQ_MAX = 64'd12884508675;
  localparam logic [npm_pkg::REQ_W-1:0] REQ_NEAREST     = 2'd0;
  localparam logic [npm_pkg::REQ_W-1:0] REQ_NEAREST_ALT = 2'd3;

  typedef struct packed {
    logic [npm_pkg::REQ_W-1:0] req;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } point_request_t;

  typedef struct packed {
    npm_pkg::res_status_t status;
    logic [npm_pkg::IDX_OUT_W-1:0] index;
    logic [npm_pkg::DIST_W-1:0] root_dist;
    logic [npm_pkg::DSQ_W-1:0] dsq;
  } match_result_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata;  // query_x, query_y, query_z
  logic [1:0] s_axis_tuser;   // req_type
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [63:0] m_axis_tdata;  // point_index, nearest_dist, nearest_dist_sq, zero pad
  logic [2:0] m_axis_tuser;   // status
  logic cfg_wr_en;
  logic [33:0] cfg_wr_data;

  nearest_point_match_or_insert #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  point_request_t pending_requests[$];
  match_result_t awaited_results[$];
  point_request_t recent_points[$];

  logic signed [15:0] stored_x[TABLE_DEPTH];
  logic signed [15:0] stored_y[TABLE_DEPTH];
  logic signed [15:0] stored_z[TABLE_DEPTH];
  int stored_count = 0;
  logic [npm_pkg::DSQ_W-1:0] match_limit = '0;

  int pushed_total = 0;
  int accepted_total = 0;
  int err_count = 0;
  int cycle_count = 0;
  logic in_fire = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  logic long_hold_req = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned t;
    res = 0;
    for (int b = npm_pkg::DIST_W - 1; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic longint unsigned point_dist_sq(input int i, input point_request_t q);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(stored_x[i]) - longint'($signed(q.x));
    dy = longint'(stored_y[i]) - longint'($signed(q.y));
    dz = longint'(stored_z[i]) - longint'($signed(q.z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  task automatic model_request(input point_request_t q, output match_result_t r);
    longint unsigned s;
    longint unsigned best_sq;
    int best;
    int n;
    r.status = npm_pkg::RES_MATCHED;
    r.index = '0;
    r.root_dist = '0;
    r.dsq = '0;
    if (q.req == npm_pkg::REQ_CLEAR) begin
      stored_count = 0;
      r.status = npm_pkg::RES_CLEARED;
    end else begin
      n = stored_count;
      best = 0;
      best_sq = 0;
      for (int i = 0; i < n; i++) begin
        s = point_dist_sq(i, q);
        if (i == 0 || s < best_sq) begin
          best_sq = s;
          best = i;
        end
      end
      if (q.req == npm_pkg::REQ_INSERT && (n == 0 || best_sq > match_limit)) begin
        if (n < TABLE_DEPTH) begin
          stored_x[n] = q.x;
          stored_y[n] = q.y;
          stored_z[n] = q.z;
          stored_count = n + 1;
          r.status = npm_pkg::RES_INSERTED;
          r.index = n[npm_pkg::IDX_OUT_W-1:0];
          r.dsq = (n == 0) ? '0 : best_sq[npm_pkg::DSQ_W-1:0];
        end else begin
          r.status = npm_pkg::RES_FULL;
          r.index = best[npm_pkg::IDX_OUT_W-1:0];
          r.dsq = best_sq[npm_pkg::DSQ_W-1:0];
          r.root_dist = npm_pkg::DIST_W'(floor_sqrt(best_sq));
        end
      end else if (n == 0) begin
        r.status = npm_pkg::RES_EMPTY;
      end else begin
        r.status = npm_pkg::RES_MATCHED;
        r.index = best[npm_pkg::IDX_OUT_W-1:0];
        r.dsq = best_sq[npm_pkg::DSQ_W-1:0];
        r.root_dist = npm_pkg::DIST_W'(floor_sqrt(best_sq));
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    match_result_t want;
    point_request_t q;
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (cfg_wr_en) match_limit = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        q.req = s_axis_tuser;
        q.x = s_axis_tdata[15:0];
        q.y = s_axis_tdata[31:16];
        q.z = s_axis_tdata[47:32];
        model_request(q, want);
        awaited_results = {awaited_results, want};
        accepted_total++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("Unexpected result transfer: status %0d index %0d dist %0d dsq %0d",
                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[24:8], m_axis_tdata[58:25]);
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser !== want.status || m_axis_tdata[7:0] !== want.index ||
              m_axis_tdata[24:8] !== want.root_dist || m_axis_tdata[58:25] !== want.dsq) begin
            err_count++;
            if (err_count <= 10)
              $display({"Mismatch: expected status %0d index %0d dist %0d dsq %0d,",
                        " got %0d %0d %0d %0d"},
                       want.status, want.index, want.root_dist, want.dsq, m_axis_tuser,
                       m_axis_tdata[7:0], m_axis_tdata[24:8], m_axis_tdata[58:25]);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    point_request_t q;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_fire) begin
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left--;
    end else if (pending_requests.size() > 0) begin
      q = pending_requests.pop_front();
      s_axis_tdata <= {q.z, q.y, q.x};
      s_axis_tuser <= q.req;
      s_axis_tvalid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(100, 300);
        gap_left = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap_left = $urandom_range(0, 8);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left = 600;
      long_hold_req = 1'b0;
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic push_item(input logic [1:0] req, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z);
    point_request_t q;
    q.req = req;
    q.x = x;
    q.y = y;
    q.z = z;
    pending_requests = {pending_requests, q};
    pushed_total++;
  endtask

  task automatic wait_idle();
    while (pending_requests.size() > 0 || accepted_total != pushed_total ||
           awaited_results.size() > 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_threshold(input longint unsigned value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value[33:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] near_coord(input logic [15:0] base, input int radius);
    logic [15:0] offset;
    offset = 16'($urandom_range(0, 2 * radius)) - 16'(radius);
    return base + offset;
  endfunction

  task automatic run_random_phase(input int count);
    point_request_t b;
    logic [1:0] req;
    int pick;
    int radius;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) req = npm_pkg::REQ_CLEAR;
      else if (pick < 50) req = npm_pkg::REQ_INSERT;
      else if (pick < 92) req = REQ_NEAREST;
      else req = REQ_NEAREST_ALT;
      if (recent_points.size() > 0 && $urandom_range(0, 1) == 1) begin
        b = recent_points[$urandom_range(0, recent_points.size() - 1)];
        case ($urandom_range(0, 3))
          0: radius = 0;
          1: radius = 4;
          2: radius = 64;
          default: radius = 512;
        endcase
        x = near_coord(b.x, radius);
        y = near_coord(b.y, radius);
        z = near_coord(b.z, radius);
      end else begin
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
      end
      push_item(req, x, y, z);
      if (req == npm_pkg::REQ_CLEAR) begin
        recent_points.delete();
      end else if (req == npm_pkg::REQ_INSERT) begin
        b.req = req;
        b.x = x;
        b.y = y;
        b.z = z;
        recent_points = {recent_points, b};
        if (recent_points.size() > 64) void'(recent_points.pop_front());
      end
    end
  endtask

  initial begin
    longint unsigned limits[5];
    logic [15:0] kx;
    logic [15:0] ky;
    logic [15:0] kz;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_threshold(0);
    push_item(REQ_NEAREST, 16'h0000, 16'h0000, 16'h0000);
    push_item(REQ_NEAREST_ALT, 16'h7fff, 16'h8000, 16'hffff);
    push_item(npm_pkg::REQ_INSERT, 16'h8000, 16'h8000, 16'h8000);
    push_item(npm_pkg::REQ_INSERT, 16'h7fff, 16'h7fff, 16'h7fff);
    push_item(REQ_NEAREST, 16'h0000, 16'h0000, 16'h0000);
    push_item(npm_pkg::REQ_INSERT, 16'h7fff, 16'h7fff, 16'h7fff);
    push_item(npm_pkg::REQ_INSERT, 16'h0000, 16'h0000, 16'h0100);
    push_item(npm_pkg::REQ_INSERT, 16'h0000, 16'h0000, 16'hff00);
    push_item(REQ_NEAREST, 16'h0000, 16'h0000, 16'h0000);
    push_item(REQ_NEAREST_ALT, 16'h8000, 16'h7fff, 16'hffff);
    push_item(npm_pkg::REQ_INSERT, 16'h0001, 16'h0000, 16'h0000);
    push_item(npm_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    push_item(REQ_NEAREST, 16'h1234, 16'h5678, 16'h9abc);
    push_item(npm_pkg::REQ_INSERT, 16'h1234, 16'hedcb, 16'h0001);
    push_item(npm_pkg::REQ_CLEAR, 16'hffff, 16'h8000, 16'h7fff);
    wait_idle();

    // With the largest threshold every insert into a non-empty table reuses a point.
    write_threshold(DSQ_MAX);
    push_item(npm_pkg::REQ_INSERT, 16'h0005, 16'h0005, 16'h0005);
    push_item(npm_pkg::REQ_INSERT, 16'h8000, 16'h8000, 16'h8000);
    push_item(REQ_NEAREST, 16'h7fff, 16'h7fff, 16'h7fff);
    push_item(npm_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // Fill the table completely, then probe it while full.
    write_threshold(0);
    kx = 16'($urandom);
    ky = 16'($urandom);
    kz = 16'($urandom);
    push_item(npm_pkg::REQ_INSERT, kx, ky, kz);
    for (int i = 1; i < TABLE_DEPTH + 6; i++)
      push_item(npm_pkg::REQ_INSERT, 16'($urandom), 16'($urandom), 16'($urandom));
    push_item(REQ_NEAREST, rand_coord(), rand_coord(), rand_coord());
    push_item(npm_pkg::REQ_INSERT, kx, ky, kz);
    push_item(REQ_NEAREST_ALT, kx, ky, kz + 16'd3);
    push_item(npm_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    limits[0] = 0;
    limits[1] = $urandom_range(0, 1 << 20);
    limits[2] = DSQ_MAX;
    limits[3] = {$urandom, $urandom} % (DSQ_MAX + 1);
    limits[4] = 1;
    for (int p = 0; p < 5; p++) begin
      write_threshold(limits[p]);
      recent_points.delete();
      push_item(npm_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
      run_random_phase(PHASE_ITEMS);
      if (p == 1) long_hold_req = 1'b1;
      wait_idle();
    end

    repeat (300) @(negedge clk);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
